// File: src/wavhp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavhp_pkg
// Shared types and constants for the wav header parser.
// ----------------------------------------------------------------------------
package wavhp_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [31:0] FMT_MIN  = 32'd16;
    localparam logic [10:0] SCANS_RESET = 11'd256;
    localparam logic [10:0] SCAN_SAT    = 11'd2047;
    localparam int          QUEUE_DEPTH = 4;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PCM    = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [3:0] ERR_TRUNCATED = 4'd0;
    localparam logic [3:0] ERR_NOT_RIFF  = 4'd1;
    localparam logic [3:0] ERR_FMT_SMALL = 4'd2;
    localparam logic [3:0] ERR_MISSING   = 4'd3;
    localparam logic [3:0] ERR_NOT_PCM   = 4'd4;
    localparam logic [3:0] ERR_CHANNELS  = 4'd5;
    localparam logic [3:0] ERR_BITS      = 4'd6;
    localparam logic [3:0] ERR_ALIGN     = 4'd7;

    typedef enum logic [2:0] {
        PH_RIFF = 3'd0,
        PH_HDR  = 3'd1,
        PH_FMT  = 3'd2,
        PH_SKIP = 3'd3,
        PH_DATA = 3'd4,
        PH_IDLE = 3'd5
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  pcm_byte;
        logic        last_data;
        logic [31:0] rate_hz;
        logic [5:0]  sample_bits;
        logic [1:0]  channel_count;
        logic [31:0] data_size;
        logic [3:0]  error_code;
    } result_t;

endpackage

// File: src/wavhp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavhp_parser
// Front end: takes one stream byte per beat, walks the riff chunks and
// produces at most one result per byte.
// ----------------------------------------------------------------------------
module wavhp_parser
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  wavhp_pkg::item_t   item,
    input  logic               cfg_we,
    input  logic [10:0]        cfg_data,
    output logic               res_valid,
    output wavhp_pkg::result_t res
);

    wavhp_pkg::phase_t phase_reg, phase_next, cur_phase;
    logic [4:0]  fc_reg, fc_next, cur_fc;
    logic [31:0] tag_reg, tag_next, cur_tag;
    logic [31:0] cl_reg, cl_next, cur_cl;
    logic [32:0] skip_reg, skip_next, cur_skip;
    logic [10:0] scan_reg, scan_next, cur_scan;
    logic [15:0] ftag_reg, ftag_next, cur_ftag;
    logic [15:0] chan_reg, chan_next, cur_chan;
    logic [31:0] rate_reg, rate_next, cur_rate;
    logic [15:0] align_reg, align_next, cur_align;
    logic [15:0] bits_reg, bits_next, cur_bits;
    logic        have_reg, have_next, cur_have;
    logic [31:0] left_reg, left_next, cur_left;
    logic [10:0] max_scans_reg;

    logic        end_req, fail_req;
    logic [3:0]  fail_code;
    logic [31:0] extra;
    logic [15:0] expect_align;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_scans_reg <= wavhp_pkg::SCANS_RESET;
        end
        else if (cfg_we)
        begin
            max_scans_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= wavhp_pkg::PH_RIFF;
            fc_reg    <= '0;
            tag_reg   <= '0;
            cl_reg    <= '0;
            skip_reg  <= '0;
            scan_reg  <= '0;
            ftag_reg  <= '0;
            chan_reg  <= '0;
            rate_reg  <= '0;
            align_reg <= '0;
            bits_reg  <= '0;
            have_reg  <= 1'b0;
            left_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            fc_reg    <= fc_next;
            tag_reg   <= tag_next;
            cl_reg    <= cl_next;
            skip_reg  <= skip_next;
            scan_reg  <= scan_next;
            ftag_reg  <= ftag_next;
            chan_reg  <= chan_next;
            rate_reg  <= rate_next;
            align_reg <= align_next;
            bits_reg  <= bits_next;
            have_reg  <= have_next;
            left_reg  <= left_next;
        end
    end

    // a first byte restarts the parse from a cleared state
    always_comb
    begin
        if (item.first_byte)
        begin
            cur_phase = wavhp_pkg::PH_RIFF;
            cur_fc    = '0;
            cur_tag   = '0;
            cur_cl    = '0;
            cur_skip  = '0;
            cur_scan  = '0;
            cur_ftag  = '0;
            cur_chan  = '0;
            cur_rate  = '0;
            cur_align = '0;
            cur_bits  = '0;
            cur_have  = 1'b0;
            cur_left  = '0;
        end
        else
        begin
            cur_phase = phase_reg;
            cur_fc    = fc_reg;
            cur_tag   = tag_reg;
            cur_cl    = cl_reg;
            cur_skip  = skip_reg;
            cur_scan  = scan_reg;
            cur_ftag  = ftag_reg;
            cur_chan  = chan_reg;
            cur_rate  = rate_reg;
            cur_align = align_reg;
            cur_bits  = bits_reg;
            cur_have  = have_reg;
            cur_left  = left_reg;
        end
    end

    always_comb
    begin
        phase_next = cur_phase;
        fc_next    = cur_fc;
        tag_next   = cur_tag;
        cl_next    = cur_cl;
        skip_next  = cur_skip;
        scan_next  = cur_scan;
        ftag_next  = cur_ftag;
        chan_next  = cur_chan;
        rate_next  = cur_rate;
        align_next = cur_align;
        bits_next  = cur_bits;
        have_next  = cur_have;
        left_next  = cur_left;
        end_req    = 1'b0;
        fail_req   = 1'b0;
        fail_code  = wavhp_pkg::ERR_TRUNCATED;
        extra      = cur_cl - wavhp_pkg::FMT_MIN;
        expect_align = '0;
        res_valid  = 1'b0;
        res        = '0;

        case (cur_phase)
            wavhp_pkg::PH_RIFF:
            begin
                tag_next = {item.data_byte, cur_tag[31:8]};
                if (cur_fc == 5'd3)
                begin
                    cl_next = tag_next;
                end
                if (cur_fc >= 5'd11)
                begin
                    if (cl_next != wavhp_pkg::TAG_RIFF || tag_next != wavhp_pkg::TAG_WAVE)
                    begin
                        fail_req  = 1'b1;
                        fail_code = wavhp_pkg::ERR_NOT_RIFF;
                    end
                    else
                    begin
                        end_req = 1'b1;
                    end
                end
                else
                begin
                    fc_next = cur_fc + 5'd1;
                end
            end
            wavhp_pkg::PH_HDR:
            begin
                if (cur_fc < 5'd4)
                begin
                    tag_next = {item.data_byte, cur_tag[31:8]};
                end
                else
                begin
                    cl_next = {item.data_byte, cur_cl[31:8]};
                end
                if (cur_fc >= 5'd7)
                begin
                    if (cur_scan < wavhp_pkg::SCAN_SAT)
                    begin
                        scan_next = cur_scan + 11'd1;
                    end
                    expect_align = {12'd0, cur_chan[1:0] * {1'b0, cur_bits[5:3]}};
                    if (tag_next == wavhp_pkg::TAG_FMT)
                    begin
                        if (cl_next < wavhp_pkg::FMT_MIN)
                        begin
                            fail_req  = 1'b1;
                            fail_code = wavhp_pkg::ERR_FMT_SMALL;
                        end
                        else
                        begin
                            phase_next = wavhp_pkg::PH_FMT;
                            fc_next    = '0;
                        end
                    end
                    else if (tag_next == wavhp_pkg::TAG_DATA)
                    begin
                        if (!cur_have)
                        begin
                            fail_req  = 1'b1;
                            fail_code = wavhp_pkg::ERR_MISSING;
                        end
                        else if (cur_ftag != 16'd1)
                        begin
                            fail_req  = 1'b1;
                            fail_code = wavhp_pkg::ERR_NOT_PCM;
                        end
                        else if (cur_chan == 16'd0 || cur_chan > 16'd2)
                        begin
                            fail_req  = 1'b1;
                            fail_code = wavhp_pkg::ERR_CHANNELS;
                        end
                        else if (cur_bits != 16'd8 && cur_bits != 16'd16 &&
                                 cur_bits != 16'd24 && cur_bits != 16'd32)
                        begin
                            fail_req  = 1'b1;
                            fail_code = wavhp_pkg::ERR_BITS;
                        end
                        else if (cur_align == 16'd0 || cur_align != expect_align)
                        begin
                            fail_req  = 1'b1;
                            fail_code = wavhp_pkg::ERR_ALIGN;
                        end
                        else
                        begin
                            res_valid         = 1'b1;
                            res.result_kind   = wavhp_pkg::KIND_HEADER;
                            res.rate_hz       = cur_rate;
                            res.sample_bits   = cur_bits[5:0];
                            res.channel_count = cur_chan[1:0];
                            res.data_size     = cl_next;
                            left_next         = cl_next;
                            phase_next = (cl_next != 32'd0) ? wavhp_pkg::PH_DATA
                                                             : wavhp_pkg::PH_IDLE;
                        end
                    end
                    else
                    begin
                        skip_next = {1'b0, cl_next} + {32'd0, cl_next[0]};
                        if (skip_next != 33'd0)
                        begin
                            phase_next = wavhp_pkg::PH_SKIP;
                        end
                        else
                        begin
                            end_req = 1'b1;
                        end
                    end
                end
                else
                begin
                    fc_next = cur_fc + 5'd1;
                end
            end
            wavhp_pkg::PH_FMT:
            begin
                tag_next = {item.data_byte, cur_tag[31:8]};
                case (cur_fc)
                    5'd1:    ftag_next  = tag_next[31:16];
                    5'd3:    chan_next  = tag_next[31:16];
                    5'd7:    rate_next  = tag_next;
                    5'd13:   align_next = tag_next[31:16];
                    5'd15:   bits_next  = tag_next[31:16];
                    default: ;
                endcase
                if (cur_fc >= 5'd15)
                begin
                    have_next = 1'b1;
                    skip_next = {1'b0, extra} + {32'd0, extra[0]};
                    if (skip_next != 33'd0)
                    begin
                        phase_next = wavhp_pkg::PH_SKIP;
                    end
                    else
                    begin
                        end_req = 1'b1;
                    end
                end
                else
                begin
                    fc_next = cur_fc + 5'd1;
                end
            end
            wavhp_pkg::PH_SKIP:
            begin
                skip_next = cur_skip - 33'd1;
                if (skip_next == 33'd0)
                begin
                    end_req = 1'b1;
                end
            end
            wavhp_pkg::PH_DATA:
            begin
                res_valid       = 1'b1;
                res.result_kind = wavhp_pkg::KIND_PCM;
                res.pcm_byte    = item.data_byte;
                res.last_data   = (cur_left <= 32'd1) || item.last_byte;
                left_next       = cur_left - 32'd1;
                if (left_next == 32'd0)
                begin
                    phase_next = wavhp_pkg::PH_IDLE;
                end
            end
            default: ;
        endcase

        // chunk finished: next header or scan limit reached
        if (end_req)
        begin
            if (scan_next >= max_scans_reg)
            begin
                fail_req  = 1'b1;
                fail_code = wavhp_pkg::ERR_MISSING;
            end
            else
            begin
                phase_next = wavhp_pkg::PH_HDR;
                fc_next    = '0;
            end
        end

        if (item.last_byte && !res_valid && !fail_req &&
            phase_next != wavhp_pkg::PH_IDLE && phase_next != wavhp_pkg::PH_DATA)
        begin
            fail_req  = 1'b1;
            fail_code = wavhp_pkg::ERR_TRUNCATED;
        end

        if (fail_req)
        begin
            res_valid      = 1'b1;
            res            = '0;
            res.result_kind = wavhp_pkg::KIND_ERROR;
            res.error_code = fail_code;
            phase_next     = wavhp_pkg::PH_IDLE;
        end

        if (item.last_byte)
        begin
            phase_next = wavhp_pkg::PH_IDLE;
        end
    end

endmodule

// File: src/wavhp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavhp_queue
// Back end: short result queue that hands results out in order.
// ----------------------------------------------------------------------------
module wavhp_queue
#(
    parameter int DEPTH = wavhp_pkg::QUEUE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  wavhp_pkg::result_t wr_data,
    input  logic               rd_en,
    output wavhp_pkg::result_t rd_data,
    output logic               full,
    output logic               empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    wavhp_pkg::result_t mem [DEPTH];
    logic [PW-1:0] wptr_reg, rptr_reg;
    logic [CW-1:0] count_reg;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wptr_reg <= (wptr_reg == LAST_PTR) ? '0 : wptr_reg + PW'(1);
            end
            if (rd_en)
            begin
                rptr_reg <= (rptr_reg == LAST_PTR) ? '0 : rptr_reg + PW'(1);
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

// File: src/wav_header_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_header_parser
// RIFF/WAVE header parser with pcm byte pass-through.
// ----------------------------------------------------------------------------
// Takes one file byte per cycle while full is low: the chunk
// parser settles each byte in a single step and drops any result into a
// result queue of DEPTH entries, so input and output stall on their own.
// full rises only when the queue holds DEPTH results nobody has popped.
// Each byte yields zero or one result: a header beat, a pcm data beat or an
// error beat. After an error, the end of data or a last byte, bytes are
// taken silently until a byte flagged first_byte restarts the parse.
module wav_header_parser
#(
    parameter int DEPTH = wavhp_pkg::QUEUE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  wavhp_pkg::item_t   item,
    input  logic               pop,
    output logic               empty,
    output wavhp_pkg::result_t result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [10:0]        cfg_data
);

    logic               accept;
    logic               res_valid;
    wavhp_pkg::result_t res;

    assign accept    = push && !full;
    assign cfg_ready = 1'b1;

    wavhp_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .res       (res)
    );

    wavhp_queue #(.DEPTH(DEPTH)) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept && res_valid),
        .wr_data (res),
        .rd_en   (pop && !empty),
        .rd_data (result),
        .full    (full),
        .empty   (empty)
    );

    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(full && empty))
        else $error("queue full and empty together");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.result_kind != 2'd3))
        else $error("illegal result kind");

    a_pcm_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.result_kind == wavhp_pkg::KIND_PCM) |->
        (result.error_code == 4'd0 && result.data_size == 32'd0))
        else $error("pcm beat carries header or error bits");

endmodule
